FILE: src/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [1:0] MODE_KEY    = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_DECRYPT = 2'd2;

    localparam logic [4:0] CODE_I    = 5'd8;
    localparam logic [4:0] CODE_J    = 5'd9;
    localparam logic [4:0] CODE_LAST = 5'd25;

    localparam logic [7:0] ASCII_A       = 8'h41;
    localparam logic [7:0] ASCII_Z       = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Cell position kept as a row and a column so that no division by five is needed.
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pos_t;

    typedef struct packed {
        logic accept;
        logic key_add;
        logic dec_start;
        logic fill_start;
        logic fill_step;
        logic sq_read;
        logic load_dec;
        logic load_plain;
    } cmd_t;

    typedef struct packed {
        logic pair_ok;
        logic walk_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: src/pfd_ram.sv
`default_nettype none

module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: src/pfd_ctrl.sv
`default_nettype none

module pfd_ctrl
    import pfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] mode,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_POS  = 5'b00100,
        ST_SQR  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_KEY:
                        begin
                            cmd.key_add = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        MODE_FINISH:
                        begin
                            cmd.fill_start = 1'b1;
                            state_next     = ST_FILL;
                        end
                        MODE_DECRYPT:
                        begin
                            cmd.dec_start = 1'b1;
                            state_next    = stat.pair_ok ? ST_POS : ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_POS:
            begin
                cmd.sq_read = 1'b1;
                state_next  = ST_SQR;
            end
            ST_SQR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_dec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_plain = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/pfd_dp.sv
`default_nettype none

module pfd_dp
    import pfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    input  wire logic [7:0] key_char,
    input  wire logic [7:0] first_letter,
    input  wire logic [7:0] second_letter,
    input  wire logic       m_tready,
    output stat_t           stat,
    output logic            m_tvalid,
    output logic [15:0]     m_tdata,
    output logic            m_tuser
);

    logic [25:0] used_reg;
    logic [25:0] used_next;
    logic [4:0]  fill_reg;
    logic [4:0]  fill_next;
    pos_t        fpos_reg;
    pos_t        fpos_next;
    logic        closed_reg;
    logic        closed_next;
    logic [4:0]  walk_reg;
    logic [4:0]  walk_next;
    logic        err_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [7:0]  key_upper;
    logic        key_letter;
    logic [7:0]  key_off;
    logic [4:0]  key_code;
    logic [4:0]  place_code;
    logic        place_valid;
    logic        restart;
    logic [25:0] base_used;
    logic [4:0]  base_fill;
    pos_t        base_pos;
    logic        do_place;
    logic        do_update;

    logic [7:0]  a_off;
    logic [7:0]  b_off;
    logic        a_found;
    logic        b_found;

    pos_t        p1;
    pos_t        p2;
    pos_t        o1;
    pos_t        o2;
    logic [4:0]  sq_addr_a;
    logic [4:0]  sq_addr_b;
    logic [4:0]  sq_data_a;
    logic [4:0]  sq_data_b;

    function automatic logic [4:0] cell_index(input pos_t p);
        logic [4:0] r5;
        logic [4:0] c5;
        r5 = {2'b00, p.row};
        c5 = {2'b00, p.col};
        return (r5 << 2) + r5 + c5;
    endfunction

    function automatic logic [2:0] dec_wrap(input logic [2:0] v);
        return (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    endfunction

    // Key character: fold case, fold J onto I.
    always_comb
    begin
        key_upper = key_char;
        if (key_char >= ASCII_LOWER_A && key_char <= ASCII_LOWER_Z)
        begin
            key_upper = key_char - CASE_OFFSET;
        end
        key_letter = (key_upper >= ASCII_A) && (key_upper <= ASCII_Z);
        key_off    = key_upper - ASCII_A;
        key_code   = (key_off[4:0] == CODE_J) ? CODE_I : key_off[4:0];
    end

    assign restart     = cmd.key_add && closed_reg;
    assign place_code  = cmd.key_add ? key_code : walk_reg;
    assign place_valid = cmd.key_add ? key_letter : (walk_reg != CODE_J);
    assign base_used   = restart ? '0 : used_reg;
    assign base_fill   = restart ? '0 : fill_reg;
    assign base_pos    = restart ? '0 : fpos_reg;
    assign do_update   = cmd.key_add || cmd.fill_step;
    assign do_place    = do_update && place_valid && !base_used[place_code]
                         && (base_fill < 5'(CELLS));

    always_comb
    begin
        used_next   = used_reg;
        fill_next   = fill_reg;
        fpos_next   = fpos_reg;
        closed_next = closed_reg;
        walk_next   = walk_reg;
        if (do_update)
        begin
            used_next = base_used;
            fill_next = base_fill;
            fpos_next = base_pos;
        end
        if (do_place)
        begin
            used_next[place_code] = 1'b1;
            fill_next             = base_fill + 5'd1;
            if (base_pos.col == 3'(SIDE - 1))
            begin
                fpos_next.col = 3'd0;
                fpos_next.row = base_pos.row + 3'd1;
            end
            else
            begin
                fpos_next.col = base_pos.col + 3'd1;
            end
        end
        if (cmd.key_add)
        begin
            closed_next = 1'b0;
        end
        if (cmd.fill_start)
        begin
            walk_next = '0;
        end
        if (cmd.fill_step)
        begin
            walk_next = walk_reg + 5'd1;
            if (walk_reg == CODE_LAST)
            begin
                closed_next = 1'b1;
            end
        end
    end

    // Pair check against the square as it stands when the word is taken.
    assign a_off   = first_letter - ASCII_A;
    assign b_off   = second_letter - ASCII_A;
    assign a_found = (first_letter >= ASCII_A) && (first_letter <= ASCII_Z)
                     && used_reg[a_off[4:0]];
    assign b_found = (second_letter >= ASCII_A) && (second_letter <= ASCII_Z)
                     && used_reg[b_off[4:0]];

    assign stat.pair_ok   = closed_reg && a_found && b_found;
    assign stat.walk_last = (walk_reg == CODE_LAST);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    pfd_ram #(
        .WIDTH ($bits(pos_t)),
        .DEPTH (LETTERS)
    ) u_pos_ram (
        .clk     (clk),
        .we      (do_place),
        .waddr   (place_code),
        .wdata   (base_pos),
        .re      (cmd.dec_start),
        .raddr_a (a_off[4:0]),
        .raddr_b (b_off[4:0]),
        .rdata_a (p1),
        .rdata_b (p2)
    );

    always_comb
    begin
        if (p1.row == p2.row)
        begin
            o1 = '{row: p1.row, col: dec_wrap(p1.col)};
            o2 = '{row: p2.row, col: dec_wrap(p2.col)};
        end
        else if (p1.col == p2.col)
        begin
            o1 = '{row: dec_wrap(p1.row), col: p1.col};
            o2 = '{row: dec_wrap(p2.row), col: p2.col};
        end
        else
        begin
            o1 = '{row: p1.row, col: p2.col};
            o2 = '{row: p2.row, col: p1.col};
        end
        sq_addr_a = cell_index(o1);
        sq_addr_b = cell_index(o2);
    end

    pfd_ram #(
        .WIDTH (5),
        .DEPTH (CELLS)
    ) u_square_ram (
        .clk     (clk),
        .we      (do_place),
        .waddr   (base_fill),
        .wdata   (place_code),
        .re      (cmd.sq_read),
        .raddr_a (sq_addr_a),
        .raddr_b (sq_addr_b),
        .rdata_a (sq_data_a),
        .rdata_b (sq_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            fill_reg     <= '0;
            fpos_reg     <= '0;
            closed_reg   <= 1'b0;
            walk_reg     <= '0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            fill_reg   <= fill_next;
            fpos_reg   <= fpos_next;
            closed_reg <= closed_next;
            walk_reg   <= walk_next;
            if (cmd.accept)
            begin
                err_reg <= cmd.dec_start && !stat.pair_ok;
            end
            if (cmd.load_dec || cmd.load_plain)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_dec)
        begin
            m_tdata_reg <= {ASCII_A + {3'b000, sq_data_b}, ASCII_A + {3'b000, sq_data_a}};
            m_tuser_reg <= 1'b0;
        end
        else if (cmd.load_plain)
        begin
            m_tdata_reg <= '0;
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: src/playfair_digraph_decrypt_top.sv
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  tuser: mode; tdata: key_char, first, second letter
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: plain_first, plain_second
//
// A key word goes through EMIT, a decrypt word through POS and SQR (EMIT when it
// reports an error), and a finish word through FILL, the walk over the 26 letters
// that fills the square. Decrypt reads the letter-position memory, then the square memory.
// Reset clears the square's letter set and fill count; the memories need no clearing.
// A result held in the output register while m_tready is low stalls the next completion.
`default_nettype none

module playfair_digraph_decrypt_top
    import pfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // key_char, first_letter, second_letter
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // plain_first, plain_second
    output logic             m_tuser    // status
);

    cmd_t  cmd;
    stat_t stat;

    pfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .key_char      (s_tdata[7:0]),
        .first_letter  (s_tdata[15:8]),
        .second_letter (s_tdata[23:16]),
        .m_tready      (m_tready),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import pfd_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key_char;
        logic [7:0] first_letter;
        logic [7:0] second_letter;
    } word_t;

    typedef struct packed {
        logic [7:0] plain_second;
        logic [7:0] plain_first;
        logic       status;
    } plain_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    word_t  words_pending[$];
    plain_t plain_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int words_queued = 0;

    int n_key = 0;
    int n_finish = 0;
    int n_decrypt = 0;
    int n_decoded = 0;
    int n_other = 0;

    // Shadow of the key square.
    logic [4:0]  sq_code[CELLS];
    logic [4:0]  cell_of_code[LETTERS];
    logic [25:0] placed_set = '0;
    int          cells_filled = 0;
    logic        square_done = 1'b0;

    playfair_digraph_decrypt_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void place_code(logic [4:0] code);
        if (!placed_set[code] && cells_filled < CELLS)
        begin
            sq_code[cells_filled[4:0]] = code;
            cell_of_code[code] = cells_filled[4:0];
            placed_set[code] = 1'b1;
            cells_filled++;
        end
    endfunction

    function automatic int cell_of_letter(logic [7:0] ch);
        logic [4:0] code;
        if (ch < ASCII_A || ch > ASCII_Z)
            return -1;
        code = 5'(ch - ASCII_A);
        if (!placed_set[code])
            return -1;
        return int'(cell_of_code[code]);
    endfunction

    function automatic plain_t decrypt_word(word_t w);
        plain_t     res;
        logic [7:0] ch;
        logic [4:0] code;
        int         pa, pb, ra, ca, rb, cb, oa, ob;
        res = '0;
        case (w.mode)
            MODE_KEY:
            begin
                n_key++;
                if (square_done)
                begin
                    placed_set = '0;
                    cells_filled = 0;
                    square_done = 1'b0;
                end
                ch = w.key_char;
                if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
                    ch = ch - CASE_OFFSET;
                if (ch >= ASCII_A && ch <= ASCII_Z)
                begin
                    code = 5'(ch - ASCII_A);
                    if (code == CODE_J)
                        code = CODE_I;
                    place_code(code);
                end
            end
            MODE_FINISH:
            begin
                n_finish++;
                for (int c = 0; c < LETTERS; c++)
                    if (c[4:0] != CODE_J)
                        place_code(c[4:0]);
                square_done = 1'b1;
            end
            MODE_DECRYPT:
            begin
                n_decrypt++;
                pa = cell_of_letter(w.first_letter);
                pb = cell_of_letter(w.second_letter);
                if (!square_done || pa < 0 || pb < 0)
                    res.status = 1'b1;
                else
                begin
                    ra = pa / SIDE;
                    ca = pa % SIDE;
                    rb = pb / SIDE;
                    cb = pb % SIDE;
                    if (ra == rb)
                    begin
                        oa = ra * SIDE + (ca + SIDE - 1) % SIDE;
                        ob = rb * SIDE + (cb + SIDE - 1) % SIDE;
                    end
                    else if (ca == cb)
                    begin
                        oa = ((ra + SIDE - 1) % SIDE) * SIDE + ca;
                        ob = ((rb + SIDE - 1) % SIDE) * SIDE + cb;
                    end
                    else
                    begin
                        oa = ra * SIDE + cb;
                        ob = rb * SIDE + ca;
                    end
                    res.plain_first = ASCII_A + {3'b000, sq_code[oa[4:0]]};
                    res.plain_second = ASCII_A + {3'b000, sq_code[ob[4:0]]};
                    n_decoded++;
                end
            end
            default:
                n_other++;
        endcase
        return res;
    endfunction

    // Sender: a new word is offered only when the previous one has gone or none is up.
    always @(posedge clk or negedge rst_n)
    begin : sender
        word_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                plain_due.push_back(decrypt_word(word_t'({s_tuser, s_tdata[7:0],
                                                          s_tdata[15:8], s_tdata[23:16]})));
            if (!s_tvalid || s_tready)
            begin
                if (words_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = words_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.mode;
                    s_tdata <= {nxt.second_letter, nxt.first_letter, nxt.key_char};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        plain_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (plain_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing due: data %h status %b",
                                 $realtime, m_tdata, m_tuser);
                end
                else
                begin
                    want = plain_due.pop_front();
                    if (m_tdata[7:0] != want.plain_first || m_tdata[15:8] != want.plain_second
                        || m_tuser != want.status)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected first %h second %h status %b, got %h %h %b",
                                     $realtime, want.plain_first, want.plain_second,
                                     want.status, m_tdata[7:0], m_tdata[15:8], m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic void queue_word(logic [1:0] mode, logic [7:0] kc, logic [7:0] fa,
                                       logic [7:0] sb);
        words_pending.push_back('{mode, kc, fa, sb});
        words_queued++;
    endfunction

    function automatic logic [7:0] square_letter();
        logic [4:0] code;
        code = 5'($urandom_range(24));
        if (code >= CODE_J)
            code++;
        return ASCII_A + {3'b000, code};
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // A key phrase, its finish, then a run of pairs, with some damage mixed in.
    function automatic void queue_session();
        int         key_len;
        int         n_pairs;
        int         pick;
        logic [7:0] ch, fa, sb;
        key_len = $urandom_range(30);
        for (int k = 0; k < key_len; k++)
        begin
            if ($urandom_range(9) < 8)
            begin
                ch = ASCII_A + 8'($urandom_range(25));
                if ($urandom_range(1) == 1)
                    ch = ch + CASE_OFFSET;
            end
            else
                ch = any_byte();
            queue_word(MODE_KEY, ch, any_byte(), any_byte());
        end
        if ($urandom_range(9) == 0)
            queue_word(MODE_DECRYPT, any_byte(), square_letter(), square_letter());
        queue_word(MODE_FINISH, any_byte(), any_byte(), any_byte());
        if ($urandom_range(9) == 0)
            queue_word(MODE_FINISH, any_byte(), any_byte(), any_byte());
        n_pairs = $urandom_range(4, 24);
        for (int k = 0; k < n_pairs; k++)
        begin
            fa = square_letter();
            sb = ($urandom_range(7) == 0) ? fa : square_letter();
            pick = $urandom_range(19);
            if (pick == 0)
                fa = any_byte();
            else if (pick == 1)
                sb = any_byte();
            else if (pick == 2)
                fa = ASCII_A + {3'b000, CODE_J};
            else if (pick == 3)
                sb = sb + CASE_OFFSET;
            queue_word(MODE_DECRYPT, any_byte(), fa, sb);
        end
        if ($urandom_range(7) == 0)
            queue_word(MODE_NONE, any_byte(), any_byte(), any_byte());
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (words_pending.size() > 0 || s_tvalid || plain_due.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int sidle, int rstall, int n_words);
        int target;
        @(negedge clk);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        target = words_queued + n_words;
        while (words_queued < target)
            queue_session();
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_word(MODE_DECRYPT, 8'h00, "A", "B");
        queue_word(MODE_KEY, "p", 8'h00, 8'h00);
        queue_word(MODE_KEY, "L", 8'h00, 8'h00);
        queue_word(MODE_KEY, "a", 8'h00, 8'h00);
        queue_word(MODE_KEY, "y", 8'h00, 8'h00);
        queue_word(MODE_KEY, "F", 8'h00, 8'h00);
        queue_word(MODE_KEY, "i", 8'h00, 8'h00);
        queue_word(MODE_KEY, "r", 8'h00, 8'h00);
        queue_word(MODE_KEY, "e", 8'h00, 8'h00);
        queue_word(MODE_KEY, "J", 8'h00, 8'h00);
        queue_word(MODE_KEY, " ", 8'h00, 8'h00);
        queue_word(MODE_KEY, 8'hFF, 8'hFF, 8'hFF);
        queue_word(MODE_DECRYPT, 8'h00, "L", "F");
        queue_word(MODE_FINISH, 8'h00, 8'h00, 8'h00);
        queue_word(MODE_FINISH, 8'hFF, 8'hFF, 8'hFF);
        queue_word(MODE_DECRYPT, 8'h00, "L", "F");
        queue_word(MODE_DECRYPT, 8'h00, "P", "I");
        queue_word(MODE_DECRYPT, 8'h00, "R", "G");
        queue_word(MODE_DECRYPT, 8'h00, "E", "E");
        queue_word(MODE_DECRYPT, 8'h00, "a", "B");
        queue_word(MODE_DECRYPT, 8'hFF, "J", 8'hFF);
        queue_word(MODE_NONE, 8'hFF, 8'hFF, 8'hFF);
        queue_word(MODE_KEY, " ", 8'h00, 8'h00);
        queue_word(MODE_DECRYPT, 8'h00, "A", "Z");
        queue_word(MODE_FINISH, 8'h00, 8'h00, 8'h00);
        queue_word(MODE_DECRYPT, 8'h00, "A", "Z");
        wait_drained();

        run_phase(0, 0, 300);
        run_phase(75, 0, 300);
        run_phase(0, 75, 300);
        run_phase(35, 35, 300);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d key, %0d finish, %0d decrypt and %0d unused-mode words;",
                 n_key, n_finish, n_decrypt, n_other);
        $display("%0d pairs decoded, with free-running, idle and stalled handshakes.",
                 n_decoded);
        if (mismatches == 0 && plain_due.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     plain_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
